// File: sv/i2cm_pkg.sv
// shared request codes and result type for the i2c master bit engine
package i2cm_pkg;

  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_WRITE = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  localparam int unsigned TICK_W = 16;
  localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 16'd1;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_input_mode;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rdata;
    logic       cmd_error;
  } i2cm_res_t;

endpackage

// File: sv/i2cm_core.sv
// bus sequencer: phase state, bit shifter, tick timer and per-request result
module i2cm_core import i2cm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TICK_W-1:0] cfg_data_i,
  input  logic              accept_i,
  input  logic [2:0]        req_type_i,
  input  logic [7:0]        wdata_i,
  input  logic              send_ack_i,
  input  logic              sda_in_i,
  output i2cm_res_t         res_o
);

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_STOP_A    = 4'd3,
    PH_STOP_B    = 4'd4,
    PH_W_LOW     = 4'd5,
    PH_W_HIGH    = 4'd6,
    PH_W_ACKLOW  = 4'd7,
    PH_W_ACKHIGH = 4'd8,
    PH_R_LOW     = 4'd9,
    PH_R_HIGH    = 4'd10,
    PH_R_ACKLOW  = 4'd11,
    PH_R_ACKHIGH = 4'd12
  } phase_e;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  phase_e            phase_q, phase_d;
  logic [2:0]        bit_cnt_q, bit_cnt_d;
  logic [7:0]        shift_q, shift_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  op_e               op_q, op_d;
  logic              ack_q, ack_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              dir_q, dir_d;
  logic [TICK_W-1:0] phase_ticks_q;
  logic [TICK_W-1:0] limit;
  logic              busy;
  logic              done;
  logic              err;

  assign limit = (phase_ticks_q == '0) ? TICK_W'(1) : phase_ticks_q;
  assign busy  = (phase_q != PH_IDLE);

  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    tick_d    = tick_q;
    op_d      = op_q;
    ack_d     = ack_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    dir_d     = dir_q;
    done      = 1'b0;
    err       = 1'b0;
    if (accept_i) begin
      case (req_type_i)
        REQ_TICK: begin
          if (busy) begin
            tick_d = tick_q + TICK_W'(1);
            if (tick_d >= limit) begin
              tick_d = '0;
              case (phase_q)
                PH_START_A: begin
                  phase_d = PH_START_B;
                  sda_d   = 1'b0;
                end
                PH_STOP_A: begin
                  phase_d = PH_STOP_B;
                  sda_d   = 1'b1;
                end
                PH_START_B, PH_STOP_B: begin
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end
                PH_W_LOW: begin
                  phase_d = PH_W_HIGH;
                  scl_d   = 1'b1;
                end
                PH_W_HIGH: begin
                  shift_d = {shift_q[6:0], 1'b0};
                  scl_d   = 1'b0;
                  if (bit_cnt_q == 3'd7) begin
                    bit_cnt_d = '0;
                    phase_d   = PH_W_ACKLOW;
                    sda_d     = 1'b1;
                  end else begin
                    bit_cnt_d = bit_cnt_q + 3'd1;
                    phase_d   = PH_W_LOW;
                    dir_d     = 1'b0;
                    sda_d     = shift_q[6];
                  end
                end
                PH_W_ACKLOW: begin
                  phase_d = PH_W_ACKHIGH;
                  scl_d   = 1'b1;
                end
                PH_R_LOW: begin
                  phase_d = PH_R_HIGH;
                  scl_d   = 1'b1;
                end
                PH_R_HIGH: begin
                  shift_d = {shift_q[6:0], sda_in_i};
                  scl_d   = 1'b0;
                  if (bit_cnt_q == 3'd7) begin
                    bit_cnt_d = '0;
                    phase_d   = PH_R_ACKLOW;
                    dir_d     = 1'b0;
                    sda_d     = ack_q;
                  end else begin
                    bit_cnt_d = bit_cnt_q + 3'd1;
                    phase_d   = PH_R_LOW;
                    sda_d     = 1'b1;
                    dir_d     = 1'b1;
                  end
                end
                PH_R_ACKLOW: begin
                  phase_d = PH_R_ACKHIGH;
                  scl_d   = 1'b1;
                end
                PH_W_ACKHIGH, PH_R_ACKHIGH: begin
                  scl_d   = 1'b0;
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end
                default: begin
                  phase_d = PH_IDLE;
                end
              endcase
            end
          end
        end
        REQ_START, REQ_STOP, REQ_WRITE, REQ_READ: begin
          if (busy) begin
            err = 1'b1;
          end else begin
            bit_cnt_d = '0;
            tick_d    = '0;
            dir_d     = 1'b0;
            case (req_type_i)
              REQ_START: begin
                op_d    = OP_START;
                phase_d = PH_START_A;
                scl_d   = 1'b1;
                sda_d   = 1'b1;
              end
              REQ_STOP: begin
                op_d    = OP_STOP;
                phase_d = PH_STOP_A;
                scl_d   = 1'b1;
                sda_d   = 1'b0;
              end
              REQ_WRITE: begin
                op_d    = OP_WRITE;
                shift_d = wdata_i;
                phase_d = PH_W_LOW;
                scl_d   = 1'b0;
                sda_d   = wdata_i[7];
              end
              default: begin
                op_d    = OP_READ;
                shift_d = '0;
                ack_d   = ~send_ack_i;
                phase_d = PH_R_LOW;
                scl_d   = 1'b0;
                sda_d   = 1'b1;
                dir_d   = 1'b1;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_o.scl            = scl_d;
    res_o.sda_out        = sda_d;
    res_o.sda_input_mode = dir_d;
    res_o.busy_res       = (phase_d != PH_IDLE);
    res_o.done_res       = done;
    res_o.rdata          = (done && op_d == OP_READ) ? shift_d : '0;
    res_o.cmd_error      = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      bit_cnt_q     <= '0;
      shift_q       <= '0;
      tick_q        <= '0;
      op_q          <= OP_START;
      ack_q         <= 1'b1;
      scl_q         <= 1'b1;
      sda_q         <= 1'b1;
      dir_q         <= 1'b0;
      phase_ticks_q <= PHASE_TICKS_RST;
    end else begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      tick_q    <= tick_d;
      op_q      <= op_d;
      ack_q     <= ack_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      dir_q     <= dir_d;
      if (cfg_we_i) begin
        phase_ticks_q <= cfg_data_i;
      end
    end
  end

  a_idle_bit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> bit_cnt_q == 3'd0)
    else $error("bit counter not cleared while idle");

  a_dir_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_q |-> (phase_q == PH_R_LOW || phase_q == PH_R_HIGH))
    else $error("sda released outside read data bits");

  a_err_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && err) |=> (phase_q == $past(phase_q) && shift_q == $past(shift_q)))
    else $error("rejected command changed state");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (phase_d == PH_IDLE && busy))
    else $error("done without completing a sequence");

endmodule

// File: sv/i2cm_out_reg.sv
// result register with stall handling between the sequencer and the output channel
module i2cm_out_reg import i2cm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  i2cm_res_t res_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output logic      full_stall_o,
  output i2cm_res_t res_o
);

  logic      valid_q, valid_d;
  i2cm_res_t res_q;

  assign full_stall_o = valid_q & out_stall_i;
  assign valid_d      = load_i | full_stall_o;
  assign out_valid_o  = valid_q;
  assign res_o        = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |-> !load_i)
    else $error("result register overwritten while stalled");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded result not presented");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_stall_i && !load_i) |=> !valid_q)
    else $error("taken result presented again");

endmodule

// File: sv/i2c_master_bit_engine_top.sv
// top level of the i2c master bit engine
// Each request (a tick, or a start, stop, write-byte or read-byte command) yields one
// result, registered on acceptance and shown in the next cycle; one request is accepted
// every cycle while the result register is free or being drained, so the sustained rate
// is one request per cycle. Bus phases last phase_ticks tick requests (zero acts as one).
// A command during a sequence is dropped, flagged with cmd_error. The user must write
// phase_ticks (always-ready config channel) only while the engine idles; not enforced.
module i2c_master_bit_engine_top import i2cm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TICK_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        req_type_i,
  input  logic [7:0]        wdata_i,
  input  logic              send_ack_i,
  input  logic              sda_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              scl_o,
  output logic              sda_out_o,
  output logic              sda_input_mode_o,
  output logic              busy_res_o,
  output logic              done_res_o,
  output logic [7:0]        rdata_o,
  output logic              cmd_error_o
);

  logic      accept;
  logic      stall;
  i2cm_res_t core_res;
  i2cm_res_t out_res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = stall;
  assign accept      = in_valid_i & ~stall;

  i2cm_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .req_type_i (req_type_i),
    .wdata_i    (wdata_i),
    .send_ack_i (send_ack_i),
    .sda_in_i   (sda_in_i),
    .res_o      (core_res)
  );

  i2cm_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .res_i        (core_res),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .full_stall_o (stall),
    .res_o        (out_res)
  );

  assign scl_o            = out_res.scl;
  assign sda_out_o        = out_res.sda_out;
  assign sda_input_mode_o = out_res.sda_input_mode;
  assign busy_res_o       = out_res.busy_res;
  assign done_res_o       = out_res.done_res;
  assign rdata_o          = out_res.rdata;
  assign cmd_error_o      = out_res.cmd_error;

endmodule

// File: bench/i2c_master_bit_engine_top_tb.sv
// self-checking testbench for the i2c master bit engine top level
module i2c_master_bit_engine_top_tb;
  import i2cm_pkg::*;

  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned MAX_WAIT = 12;

  typedef enum logic [3:0] {
    BUS_IDLE, START_HOLD, START_FALL, STOP_HOLD, STOP_RISE,
    WR_LOW, WR_HIGH, WR_ACK_LOW, WR_ACK_HIGH,
    RD_LOW, RD_HIGH, RD_ACK_LOW, RD_ACK_HIGH
  } bus_phase_e;

  typedef enum logic [1:0] {OP_START, OP_STOP, OP_WRITE, OP_READ} bus_op_e;

  class bus_level_scoreboard;
    i2cm_res_t expected_levels[$];
    int unsigned mismatches;
    logic [TICK_W-1:0] phase_ticks;
    bus_phase_e bus_phase;
    bus_op_e op;
    logic [2:0] bit_count;
    logic [7:0] shifter;
    logic [TICK_W-1:0] tick_count;
    logic ack_level;
    logic scl_level;
    logic sda_level;
    logic sda_released;

    function new();
      mismatches = 0;
      phase_ticks = PHASE_TICKS_RST;
      bus_phase = BUS_IDLE;
      op = OP_START;
      bit_count = '0;
      shifter = '0;
      tick_count = '0;
      ack_level = 1'b1;
      scl_level = 1'b1;
      sda_level = 1'b1;
      sda_released = 1'b0;
    endfunction

    function void set_phase_ticks(logic [TICK_W-1:0] value);
      phase_ticks = value;
    endfunction

    function bit engine_busy();
      return bus_phase != BUS_IDLE;
    endfunction

    function int outstanding();
      return expected_levels.size();
    endfunction

    function void enter_phase(bus_phase_e p);
      bus_phase = p;
      tick_count = '0;
      case (p)
        START_HOLD: begin
          scl_level = 1'b1; sda_level = 1'b1; sda_released = 1'b0;
        end
        START_FALL: sda_level = 1'b0;
        STOP_HOLD: begin
          scl_level = 1'b1; sda_level = 1'b0; sda_released = 1'b0;
        end
        STOP_RISE: sda_level = 1'b1;
        WR_LOW: begin
          scl_level = 1'b0; sda_released = 1'b0; sda_level = shifter[7];
        end
        WR_HIGH: scl_level = 1'b1;
        WR_ACK_LOW: begin
          scl_level = 1'b0; sda_level = 1'b1;
        end
        WR_ACK_HIGH: scl_level = 1'b1;
        RD_LOW: begin
          scl_level = 1'b0; sda_level = 1'b1; sda_released = 1'b1;
        end
        RD_HIGH: scl_level = 1'b1;
        RD_ACK_LOW: begin
          scl_level = 1'b0; sda_released = 1'b0; sda_level = ack_level;
        end
        RD_ACK_HIGH: scl_level = 1'b1;
        default: ;
      endcase
    endfunction

    // returns 1 when the sequence completes
    function bit advance_phase(logic sda_in);
      case (bus_phase)
        START_HOLD: enter_phase(START_FALL);
        STOP_HOLD: enter_phase(STOP_RISE);
        START_FALL, STOP_RISE: begin
          enter_phase(BUS_IDLE);
          return 1'b1;
        end
        WR_LOW: enter_phase(WR_HIGH);
        WR_HIGH: begin
          shifter = {shifter[6:0], 1'b0};
          if (bit_count == 3'd7) begin
            bit_count = '0;
            enter_phase(WR_ACK_LOW);
          end else begin
            bit_count = bit_count + 3'd1;
            enter_phase(WR_LOW);
          end
        end
        WR_ACK_LOW: enter_phase(WR_ACK_HIGH);
        RD_LOW: enter_phase(RD_HIGH);
        RD_HIGH: begin
          shifter = {shifter[6:0], sda_in};
          if (bit_count == 3'd7) begin
            bit_count = '0;
            enter_phase(RD_ACK_LOW);
          end else begin
            bit_count = bit_count + 3'd1;
            enter_phase(RD_LOW);
          end
        end
        RD_ACK_LOW: enter_phase(RD_ACK_HIGH);
        WR_ACK_HIGH, RD_ACK_HIGH: begin
          scl_level = 1'b0;
          enter_phase(BUS_IDLE);
          return 1'b1;
        end
        default: enter_phase(BUS_IDLE);
      endcase
      return 1'b0;
    endfunction

    function i2cm_res_t bus_levels_after(logic [2:0] req, logic [7:0] wdata,
                                         logic send_ack, logic sda_in);
      i2cm_res_t res;
      logic [TICK_W-1:0] limit;
      bit done;
      bit err;
      bit was_busy;
      done = 1'b0;
      err = 1'b0;
      was_busy = engine_busy();
      limit = (phase_ticks == '0) ? TICK_W'(1) : phase_ticks;
      case (req)
        REQ_TICK: begin
          if (was_busy) begin
            tick_count = tick_count + TICK_W'(1);
            if (tick_count >= limit) done = advance_phase(sda_in);
          end
        end
        REQ_START, REQ_STOP, REQ_WRITE, REQ_READ: begin
          if (was_busy) begin
            err = 1'b1;
          end else begin
            bit_count = '0;
            case (req)
              REQ_START: begin
                op = OP_START; enter_phase(START_HOLD);
              end
              REQ_STOP: begin
                op = OP_STOP; enter_phase(STOP_HOLD);
              end
              REQ_WRITE: begin
                op = OP_WRITE; shifter = wdata; enter_phase(WR_LOW);
              end
              default: begin
                op = OP_READ; shifter = '0; ack_level = !send_ack;
                enter_phase(RD_LOW);
              end
            endcase
          end
        end
        default: ;
      endcase
      res.scl = scl_level;
      res.sda_out = sda_level;
      res.sda_input_mode = sda_released;
      res.busy_res = engine_busy();
      res.done_res = done;
      res.rdata = (done && op == OP_READ) ? shifter : 8'h00;
      res.cmd_error = err;
      return res;
    endfunction

    function void note_request(logic [2:0] req, logic [7:0] wdata,
                               logic send_ack, logic sda_in);
      expected_levels.push_back(bus_levels_after(req, wdata, send_ack, sda_in));
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(i2cm_res_t got);
      i2cm_res_t want;
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_levels.pop_front();
      compare_field("scl", 8'(want.scl), 8'(got.scl));
      compare_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
      compare_field("sda_input_mode", 8'(want.sda_input_mode), 8'(got.sda_input_mode));
      compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
      compare_field("rdata", want.rdata, got.rdata);
      compare_field("cmd_error", 8'(want.cmd_error), 8'(got.cmd_error));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [TICK_W-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [2:0]        req_type_i;
  logic [7:0]        wdata_i;
  logic              send_ack_i;
  logic              sda_in_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              scl_o;
  logic              sda_out_o;
  logic              sda_input_mode_o;
  logic              busy_res_o;
  logic              done_res_o;
  logic [7:0]        rdata_o;
  logic              cmd_error_o;

  bus_level_scoreboard sb;
  bit idling;
  int unsigned long_hold;

  i2c_master_bit_engine_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .wdata_i          (wdata_i),
    .send_ack_i       (send_ack_i),
    .sda_in_i         (sda_in_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .scl_o            (scl_o),
    .sda_out_o        (sda_out_o),
    .sda_input_mode_o (sda_input_mode_o),
    .busy_res_o       (busy_res_o),
    .done_res_o       (done_res_o),
    .rdata_o          (rdata_o),
    .cmd_error_o      (cmd_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("i2c_master_bit_engine_top_tb: done, errors");
    $finish;
  end

  // result side
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result({scl_o, sda_out_o, sda_input_mode_o, busy_res_o, done_res_o,
                         rdata_o, cmd_error_o});
        stall_left = idling ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (long_hold > 0) begin
        stall_left = long_hold;
        long_hold = 0;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_request(input logic [2:0] req, input logic [7:0] wdata,
                              input logic send_ack, input logic sda_in);
    int unsigned gap;
    gap = idling ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    wdata_i <= wdata;
    send_ack_i <= send_ack;
    sda_in_i <= sda_in;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req, wdata, send_ack, sda_in);
  endtask

  task automatic send_tick();
    send_request(REQ_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic finish_sequence();
    while (sb.engine_busy()) send_tick();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() > 0);
  endtask

  task automatic change_phase_ticks(input logic [TICK_W-1:0] value);
    finish_sequence();
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_phase_ticks(value);
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < count) begin
      if (sent % 100 == 0) idling = ($urandom_range(0, 3) != 0);
      if (!sb.engine_busy()) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          send_tick();
        end else if (pick == 1) begin
          send_request(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), 8'($urandom),
                       1'($urandom), 1'($urandom));
        end else begin
          send_request(3'($urandom_range(REQ_START, REQ_READ)), 8'($urandom),
                       1'($urandom), 1'($urandom));
          sent++;
        end
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          send_request(3'($urandom_range(REQ_START, REQ_READ)), 8'($urandom),
                       1'($urandom), 1'($urandom));
          sent++;
        end else if (pick == 1) begin
          send_request(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), 8'($urandom),
                       1'($urandom), 1'($urandom));
        end else begin
          send_tick();
          sent++;
        end
      end
    end
    idling = 1'b1;
  endtask

  initial begin
    sb = new();
    idling = 1'b1;
    long_hold = 0;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    req_type_i <= REQ_TICK;
    wdata_i <= '0;
    send_ack_i <= 1'b0;
    sda_in_i <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle tick, unused codes, command while busy
    send_request(REQ_TICK, 8'h00, 1'b0, 1'b0);
    send_request(REQ_UNUSED_LO, 8'hFF, 1'b1, 1'b1);
    send_request(REQ_UNUSED_HI, 8'h00, 1'b0, 1'b0);
    send_request(REQ_START, 8'h00, 1'b0, 1'b0);
    send_request(REQ_WRITE, 8'hFF, 1'b1, 1'b1);
    finish_sequence();
    send_request(REQ_STOP, 8'h00, 1'b0, 1'b0);
    finish_sequence();
    send_request(REQ_WRITE, 8'hFF, 1'b0, 1'b0);
    finish_sequence();
    send_request(REQ_WRITE, 8'h00, 1'b1, 1'b1);
    finish_sequence();
    send_request(REQ_READ, 8'h00, 1'b1, 1'b1);
    finish_sequence();
    send_request(REQ_READ, 8'hFF, 1'b0, 1'b0);
    finish_sequence();

    change_phase_ticks('0);
    random_traffic(450);

    change_phase_ticks(TICK_W'(2));
    long_hold = 300;
    random_traffic(450);

    change_phase_ticks(TICK_W'(3));
    random_traffic(450);

    // longer phase: one start sequence with no idling
    change_phase_ticks(TICK_W'(9));
    idling = 1'b0;
    send_request(REQ_START, 8'h00, 1'b0, 1'b0);
    send_request(REQ_READ, 8'hFF, 1'b1, 1'b1);
    finish_sequence();
    idling = 1'b1;

    change_phase_ticks(TICK_W'(1));
    random_traffic(450);

    finish_sequence();
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("i2c_master_bit_engine_top_tb: done, clean");
    end else begin
      $display("i2c_master_bit_engine_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: i2c_master_bit_engine_top.f
sv/i2cm_pkg.sv
sv/i2cm_core.sv
sv/i2cm_out_reg.sv
sv/i2c_master_bit_engine_top.sv
bench/i2c_master_bit_engine_top_tb.sv
